>>> hdl/tpbd_pkg.sv
// shared widths, reset values, register indexes and stage structs for the touch pad block
`default_nettype none

package tpbd_pkg;

  // field widths
  localparam int PAD_W = 4;
  localparam int RAW_W = 16;
  localparam int SUM_W = 20;
  localparam int PCT_W = 7;
  localparam int DEB_W = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  // default sizes
  localparam int PAD_COUNT_DEF = 2;
  localparam int CALIB_SAMPLES_DEF = 16;

  // register reset values
  localparam logic [PCT_W-1:0] PCT_RST = PCT_W'(40);
  localparam logic [DEB_W-1:0] DEB_RST = DEB_W'(2);
  localparam logic [RAW_W-1:0] MAX_RST = RAW_W'(20000);

  // scale of the threshold percentage
  localparam int PCT_SCALE = 100;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD_PERCENT = 2'd0,
    REG_DEB_LIMIT         = 2'd1,
    REG_MAX_COUNT         = 2'd2
  } tpbd_reg_t;

  // configuration as seen by the datapath
  typedef struct packed {
    logic [PCT_W-1:0] threshold_percent;
    logic [DEB_W-1:0] deb_limit;
    logic [RAW_W-1:0] max_count;
  } tpbd_cfg_t;

  // request held in the input register
  typedef struct packed {
    logic [PAD_W-1:0] pad;
    logic [RAW_W-1:0] raw;
    logic             in_range;
  } tpbd_item_t;

  // result handed to the output register
  typedef struct packed {
    logic [PAD_W-1:0] pad_out;
    logic             touched;
    logic             calibrating;
    logic             changed;
  } tpbd_result_t;

endpackage

`default_nettype wire

>>> hdl/touch_pad_baseline_debounce.sv
// top level: configuration registers, input register, pad state and output register
//
//  channel  | ports                                  | direction
//  ---------+----------------------------------------+----------
//  input    | in_valid/in_ready, in_pad, in_raw_count | in
//  result   | out_valid/out_ready, out_pad_out,       | out
//           | out_touched, out_calibrating, out_changed|
//  config   | cfg_we, cfg_index, cfg_wdata            | in
//
// One request per cycle sustained while results are taken; each result
// passes through the input register and then the output register, which
// loads it only when it has room. The per-pad state update is combinational
// between the two registers, so requests for the same pad may follow back to
// back. Reset is synchronous and clears all pad state at once. A stalled
// result holds the output register while the input register still takes
// one more request.
`default_nettype none

module touch_pad_baseline_debounce
  import tpbd_pkg::*;
#(
  parameter int PAD_COUNT     = PAD_COUNT_DEF,
  parameter int CALIB_SAMPLES = CALIB_SAMPLES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [PAD_W-1:0]      in_pad,
  input  wire logic [RAW_W-1:0]      in_raw_count,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [PAD_W-1:0]           out_pad_out,
  output logic                       out_touched,
  output logic                       out_calibrating,
  output logic                       out_changed,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  tpbd_cfg_t    cfg_r;
  tpbd_item_t   item;
  tpbd_result_t result, out_result;
  logic         item_valid, sink_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold_percent <= PCT_RST;
      cfg_r.deb_limit         <= DEB_RST;
      cfg_r.max_count         <= MAX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_THRESHOLD_PERCENT: cfg_r.threshold_percent <= cfg_wdata[PCT_W-1:0];
        REG_DEB_LIMIT:         cfg_r.deb_limit         <= cfg_wdata[DEB_W-1:0];
        REG_MAX_COUNT:         cfg_r.max_count         <= cfg_wdata[RAW_W-1:0];
        default: ;
      endcase
    end
  end

  tpbd_in_stage #(
    .PAD_COUNT (PAD_COUNT)
  ) u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_pad       (in_pad),
    .in_raw_count (in_raw_count),
    .max_count    (cfg_r.max_count),
    .sink_ready   (sink_ready),
    .item_valid   (item_valid),
    .item         (item)
  );

  tpbd_pad_core #(
    .PAD_COUNT     (PAD_COUNT),
    .CALIB_SAMPLES (CALIB_SAMPLES)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .item_valid (item_valid),
    .item       (item),
    .sink_ready (sink_ready),
    .result     (result)
  );

  tpbd_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .result     (result),
    .sink_ready (sink_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_result (out_result)
  );

  assign out_pad_out     = out_result.pad_out;
  assign out_touched     = out_result.touched;
  assign out_calibrating = out_result.calibrating;
  assign out_changed     = out_result.changed;

  // out-of-range pad reports no flags set
  a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ({1'b0, out_pad_out} >= (PAD_W + 1)'(PAD_COUNT)))
      |-> (!out_touched && !out_calibrating && !out_changed))
    else $error("out-of-range pad reported state");

  // a calibration reading never flips the flag
  a_calib_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_calibrating && out_changed))
    else $error("flag changed on a calibration reading");

  // a held request stays put while the output register is blocked
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (item_valid && out_valid && !out_ready) |=> (item_valid && $stable(item)))
    else $error("input register lost a request during a stall");

  // the input side is refused only when both registers are full and blocked
  a_ready_when_room: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (item_valid && out_valid && !out_ready))
    else $error("input refused with room available");

endmodule

`default_nettype wire

>>> hdl/tpbd_in_stage.sv
// input register: takes a request, saturates the reading and checks the pad index
`default_nettype none

module tpbd_in_stage
  import tpbd_pkg::*;
#(
  parameter int PAD_COUNT = PAD_COUNT_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [PAD_W-1:0] in_pad,
  input  wire logic [RAW_W-1:0] in_raw_count,
  input  wire logic [RAW_W-1:0] max_count,
  input  wire logic             sink_ready,
  output logic                  item_valid,
  output tpbd_item_t            item
);

  logic       valid_r, valid_nxt;
  tpbd_item_t item_r, item_nxt;
  logic       take, accept;

  // request moves on when the next stage has room
  assign take     = valid_r && sink_ready;
  assign in_ready = !valid_r || take;
  assign accept   = in_valid && in_ready;

  // saturate and range check on the way in
  always_comb begin
    item_nxt.pad      = in_pad;
    item_nxt.raw      = (in_raw_count > max_count) ? max_count : in_raw_count;
    item_nxt.in_range = ({1'b0, in_pad} < (PAD_W + 1)'(PAD_COUNT));
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_nxt;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

`default_nettype wire

>>> hdl/tpbd_pad_core.sv
// per-pad state: calibration sum, baseline, threshold compare and debounce
`default_nettype none

module tpbd_pad_core
  import tpbd_pkg::*;
#(
  parameter int PAD_COUNT     = PAD_COUNT_DEF,
  parameter int CALIB_SAMPLES = CALIB_SAMPLES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire tpbd_cfg_t  cfg,
  input  wire logic       item_valid,
  input  wire tpbd_item_t item,
  input  wire logic       sink_ready,
  output tpbd_result_t    result
);

  localparam int PAD_IW  = (PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1;
  localparam int CNT_W   = $clog2(CALIB_SAMPLES + 1);
  localparam int CLOG    = $clog2(CALIB_SAMPLES);
  localparam int SHIFT   = SUM_W + CLOG;
  localparam int RECIP_W = SUM_W + 1;
  localparam int PROD_W  = SUM_W + RECIP_W;
  localparam int MUL_W   = RAW_W + PCT_W;
  // reciprocal that makes the multiply-and-shift an exact floor divide
  localparam longint unsigned RECIP_L =
    ((64'd1 << SHIFT) + 64'(CALIB_SAMPLES) - 64'd1) / 64'(CALIB_SAMPLES);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
  localparam logic [CNT_W-1:0]   CALIB_N = CNT_W'(CALIB_SAMPLES);

  logic [CNT_W-1:0] samples_r  [PAD_COUNT];
  logic [SUM_W-1:0] sum_r      [PAD_COUNT];
  logic [RAW_W-1:0] base_r     [PAD_COUNT];
  logic             flag_r     [PAD_COUNT];
  logic [DEB_W-1:0] run_r      [PAD_COUNT];

  logic [PAD_IW-1:0] idx;
  logic [CNT_W-1:0]  cur_samples, samples_nxt;
  logic [SUM_W-1:0]  cur_sum, sum_nxt;
  logic [RAW_W-1:0]  cur_base, base_nxt;
  logic              cur_flag, flag_nxt;
  logic [DEB_W-1:0]  cur_run, run_nxt;
  logic [DEB_W:0]    run_inc;
  logic [PROD_W-1:0] quot_prod;
  logic [RAW_W-1:0]  diff;
  logic [MUL_W-1:0]  diff_scaled, base_scaled;
  logic              calib, above, changed, upd;

  assign idx         = item.pad[PAD_IW-1:0];
  assign cur_samples = samples_r[idx];
  assign cur_sum     = sum_r[idx];
  assign cur_base    = base_r[idx];
  assign cur_flag    = flag_r[idx];
  assign cur_run     = run_r[idx];

  assign upd   = item_valid && sink_ready && item.in_range;
  assign calib = (cur_samples < CALIB_N);

  // calibration accumulate and baseline divide by reciprocal multiply
  assign sum_nxt     = cur_sum + SUM_W'(item.raw);
  assign samples_nxt = cur_samples + CNT_W'(1);
  assign quot_prod   = PROD_W'(sum_nxt) * PROD_W'(RECIP);

  // raw > base + floor(base*pct/100)  <=>  raw > base and 100*(raw-base) > base*pct
  assign diff        = item.raw - cur_base;
  assign diff_scaled = MUL_W'(diff) * MUL_W'(PCT_SCALE);
  assign base_scaled = MUL_W'(cur_base) * MUL_W'(cfg.threshold_percent);
  assign above       = (item.raw > cur_base) && (diff_scaled > base_scaled);
  assign run_inc     = {1'b0, cur_run} + (DEB_W + 1)'(1);

  // next state of the addressed pad
  always_comb begin
    base_nxt = cur_base;
    flag_nxt = cur_flag;
    run_nxt  = cur_run;
    changed  = 1'b0;
    if (calib) begin
      if (samples_nxt >= CALIB_N) begin
        base_nxt = quot_prod[SHIFT +: RAW_W];
      end
    end else if (above != cur_flag) begin
      if (run_inc >= {1'b0, cfg.deb_limit}) begin
        flag_nxt = above;
        run_nxt  = '0;
        changed  = 1'b1;
      end else begin
        run_nxt = run_inc[DEB_W-1:0];
      end
    end else begin
      run_nxt = '0;
    end
  end

  // result fields; out-of-range pads report all flags zero
  always_comb begin
    result.pad_out     = item.pad;
    result.touched     = item.in_range && flag_nxt;
    result.calibrating = item.in_range && calib;
    result.changed     = item.in_range && changed;
  end

  // state update, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PAD_COUNT; i++) begin
        samples_r[i] <= '0;
        sum_r[i]     <= '0;
        base_r[i]    <= '0;
        flag_r[i]    <= 1'b0;
        run_r[i]     <= '0;
      end
    end else if (upd) begin
      if (calib) begin
        samples_r[idx] <= samples_nxt;
        sum_r[idx]     <= sum_nxt;
      end
      base_r[idx] <= base_nxt;
      flag_r[idx] <= flag_nxt;
      run_r[idx]  <= run_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hdl/tpbd_out_stage.sv
// output register holding one result until the consumer takes it
`default_nettype none

module tpbd_out_stage
  import tpbd_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         item_valid,
  input  wire tpbd_result_t result,
  output logic              sink_ready,
  output logic              out_valid,
  input  wire logic         out_ready,
  output tpbd_result_t      out_result
);

  logic         valid_r, valid_nxt;
  tpbd_result_t result_r;
  logic         load;

  // room when empty or when the held result leaves this cycle
  assign sink_ready = !valid_r || out_ready;
  assign load       = item_valid && sink_ready;

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= result;
    end
  end

  assign out_valid  = valid_r;
  assign out_result = result_r;

endmodule

`default_nettype wire

>>> dv/touch_pad_baseline_debounce_test.sv
// testbench for the touch pad baseline, threshold and debounce block
`timescale 1ns / 100ps

module touch_pad_baseline_debounce_test;
  import tpbd_pkg::*;

  localparam int PADS = PAD_COUNT_DEF;
  localparam int CAL_READS = CALIB_SAMPLES_DEF;
  // no request taken on either channel for this long means a hang
  localparam int STALL_LIMIT = 2000;
  // two register stages, plus margin
  localparam int DRAIN_CYCLES = 4;
  localparam int CHUNK_READS = 133;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [PAD_W-1:0]      in_pad = '0;
  logic [RAW_W-1:0]      in_raw_count = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [PAD_W-1:0]      out_pad_out;
  logic                  out_touched;
  logic                  out_calibrating;
  logic                  out_changed;
  logic                  cfg_we = 1'b0;
  tpbd_reg_t             cfg_index = REG_THRESHOLD_PERCENT;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // predicted register contents
  logic [PCT_W-1:0] pct_now;
  logic [DEB_W-1:0] deb_now;
  logic [RAW_W-1:0] max_now;

  // predicted per-pad state
  logic [4:0]       cal_taken [PADS];
  logic [SUM_W-1:0] cal_total [PADS];
  logic [RAW_W-1:0] base_level [PADS];
  logic             touch_state [PADS];
  logic [DEB_W-1:0] flip_run [PADS];

  // results still owed by the block, oldest first
  tpbd_result_t touch_results_due[$];

  // stimulus shaping: intended level and remaining run length per pad
  logic aim_above [PADS];
  int   run_left [PADS];

  int unsigned error_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned stall_request = 0;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;

  touch_pad_baseline_debounce uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_pad          (in_pad),
    .in_raw_count    (in_raw_count),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pad_out     (out_pad_out),
    .out_touched     (out_touched),
    .out_calibrating (out_calibrating),
    .out_changed     (out_changed),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // touch threshold for a calibrated pad under the current percentage
  function automatic int unsigned touch_limit(int pad_idx);
    int unsigned base;
    base = 32'(base_level[pad_idx]);
    return base + (base * 32'(pct_now)) / PCT_SCALE;
  endfunction

  // update the pad state for one taken reading and queue its result
  function automatic void track_pad_reading(logic [PAD_W-1:0] pad, logic [RAW_W-1:0] raw);
    tpbd_result_t res;
    logic [RAW_W-1:0] reading;
    logic above;
    int unsigned run;
    res = '0;
    res.pad_out = pad;
    reading = raw;
    if (pad < PADS) begin
      if (reading > max_now) reading = max_now;
      if (cal_taken[pad] < CAL_READS) begin
        // calibration: accumulate, baseline set on the last one
        res.calibrating = 1'b1;
        cal_total[pad] = cal_total[pad] + SUM_W'(reading);
        cal_taken[pad] = cal_taken[pad] + 5'd1;
        if (cal_taken[pad] >= CAL_READS) base_level[pad] = RAW_W'(cal_total[pad] / CAL_READS);
      end else begin
        // threshold compare and debounce
        above = (32'(reading) > touch_limit(pad));
        if (above != touch_state[pad]) begin
          run = 32'(flip_run[pad]) + 1;
          if (run >= 32'(deb_now)) begin
            touch_state[pad] = above;
            flip_run[pad] = '0;
            res.changed = 1'b1;
          end else begin
            flip_run[pad] = DEB_W'(run);
          end
        end else begin
          flip_run[pad] = '0;
        end
      end
      res.touched = touch_state[pad];
    end
    touch_results_due.push_back(res);
  endfunction

  // offer one request and wait until it is taken
  task automatic send_reading(input int unsigned pad, input int unsigned raw);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pad <= PAD_W'(pad);
    in_raw_count <= RAW_W'(raw);
    do @(posedge clk); while (!in_ready);
    track_pad_reading(PAD_W'(pad), RAW_W'(raw));
  endtask

  // stop offering and let every owed result come out
  task automatic settle_block();
    in_valid <= 1'b0;
    while (touch_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // write all three registers while the block is idle
  task automatic load_settings(input int unsigned pct, input int unsigned deb,
                               input int unsigned maxc);
    settle_block();
    cfg_we <= 1'b1;
    cfg_index <= REG_THRESHOLD_PERCENT;
    cfg_wdata <= CFG_DATA_W'(pct);
    @(posedge clk);
    pct_now = PCT_W'(pct);
    cfg_index <= REG_DEB_LIMIT;
    cfg_wdata <= CFG_DATA_W'(deb);
    @(posedge clk);
    deb_now = DEB_W'(deb);
    cfg_index <= REG_MAX_COUNT;
    cfg_wdata <= CFG_DATA_W'(maxc);
    @(posedge clk);
    max_now = RAW_W'(maxc);
    cfg_we <= 1'b0;
  endtask

  // random reading: mostly runs above or below the threshold, some noise
  task automatic send_random_reading();
    logic [PAD_W-1:0] pad;
    logic [RAW_W-1:0] raw;
    int unsigned lim;
    int unsigned lo;
    int unsigned hi;
    if ($urandom_range(99) < 12) pad = PAD_W'($urandom_range(15));
    else pad = PAD_W'($urandom_range(PADS - 1));
    raw = RAW_W'($urandom_range(16'hFFFF));
    if (pad < PADS && $urandom_range(9) != 0) begin
      if (run_left[pad] == 0) begin
        aim_above[pad] = !aim_above[pad];
        run_left[pad] = $urandom_range(deb_now + 3, 1);
      end
      run_left[pad]--;
      lim = touch_limit(pad);
      if (aim_above[pad]) begin
        lo = lim + 1;
        hi = lim + lim / 4 + 50;
      end else begin
        lo = (lim > lim / 4 + 50) ? lim - lim / 4 - 50 : 0;
        hi = lim;
      end
      if (lo > 16'hFFFF) lo = 16'hFFFF;
      if (hi > 16'hFFFF) hi = 16'hFFFF;
      raw = RAW_W'($urandom_range(hi, lo));
    end
    send_reading(pad, raw);
  endtask

  // result checker
  always @(posedge clk) begin
    tpbd_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (touch_results_due.size() == 0) begin
        $error("result for pad %0d with no request outstanding", out_pad_out);
        error_count++;
      end else begin
        want = touch_results_due.pop_front();
        if (out_pad_out !== want.pad_out) begin
          $error("pad_out: expected %0d, actual %0d", want.pad_out, out_pad_out);
          error_count++;
        end
        if (out_touched !== want.touched) begin
          $error("touched: expected %0d, actual %0d", want.touched, out_touched);
          error_count++;
        end
        if (out_calibrating !== want.calibrating) begin
          $error("calibrating: expected %0d, actual %0d", want.calibrating, out_calibrating);
          error_count++;
        end
        if (out_changed !== want.changed) begin
          $error("changed: expected %0d, actual %0d", want.changed, out_changed);
          error_count++;
        end
      end
    end
  end

  // result side ready, with random idling and long hold-offs on request
  always @(posedge clk) begin
    if (stall_request != 0) begin
      stall_left = stall_request;
      stall_request = 0;
    end
    if (stall_left != 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog on cycles with no request taken on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("touch_pad_baseline_debounce_test: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // calibrate pad 0 near 1000 and pad 1 near the saturation limit
  task automatic test_calibration();
    send_reading(0, 16'h0000);
    send_reading(1, 16'hFFFF);
    send_reading(15, 16'hFFFF);
    send_reading(1, 20001);
    send_reading(1, 20000);
    send_reading(2, 16'h0000);
    for (int i = 0; i < 15; i++) send_reading(0, $urandom_range(1100, 900));
    for (int i = 0; i < 13; i++) send_reading(1, $urandom_range(16'hFFFF, 15000));
  endtask

  // threshold edge, run cleared by an agreeing reading, flip and flip back
  task automatic test_debounce();
    int unsigned lim;
    lim = touch_limit(0);
    send_reading(0, RAW_W'(lim));
    send_reading(0, RAW_W'(lim + 1));
    send_reading(1, 16'hFFFF);
    send_reading(0, RAW_W'(lim));
    send_reading(0, RAW_W'(lim + 1));
    send_reading(0, 16'hFFFF);
    send_reading(0, 16'h0000);
    send_reading(0, 16'h0000);
    send_reading(9, 12345);
  endtask

  // register extremes, including the out-of-range values
  task automatic test_settings_extremes();
    int unsigned lim;
    load_settings(0, 1, 16'hFFFF);
    lim = touch_limit(1);
    send_reading(1, RAW_W'(lim + 1));
    send_reading(1, RAW_W'(lim));
    send_reading(1, 16'hFFFF);
    // percent above 100, debounce of zero, max count of zero
    load_settings(16'hFFFF, 16'hFFF0, 0);
    send_reading(1, 16'hFFFF);
    send_reading(0, 16'hFFFF);
    load_settings(127, 1, 16'hFFFF);
    lim = touch_limit(0);
    send_reading(0, RAW_W'(lim + 1));
    send_reading(0, RAW_W'(lim));
    load_settings(100, 15, 1);
    send_reading(0, 16'hFFFF);
    send_reading(1, 16'h0001);
  endtask

  // receiver holds off long enough for the block to back up its input
  task automatic test_backpressure();
    load_settings(40, 2, 20000);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_request = 300;
    repeat (24) send_random_reading();
  endtask

  // random traffic in three idling phases, a few settings per phase
  task automatic test_random_traffic();
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 64 : 0;
      recv_idle_pct = (phase == 0) ? 64 : (phase == 1) ? 13 : 0;
      for (int chunk = 0; chunk < 4; chunk++) begin
        load_settings(($urandom_range(9) == 0) ? $urandom_range(127, 101) : $urandom_range(100),
                      $urandom_range(15, 1),
                      ($urandom_range(3) == 0) ? 16'hFFFF : $urandom_range(16'hFFFF, 1));
        repeat (CHUNK_READS) send_random_reading();
      end
    end
  endtask

  // main sequence
  initial begin
    pct_now = PCT_RST;
    deb_now = DEB_RST;
    max_now = MAX_RST;
    for (int i = 0; i < PADS; i++) begin
      cal_taken[i] = '0;
      cal_total[i] = '0;
      base_level[i] = '0;
      touch_state[i] = 1'b0;
      flip_run[i] = '0;
      aim_above[i] = 1'b0;
      run_left[i] = 0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_calibration();
    test_debounce();
    test_settings_extremes();
    test_backpressure();
    test_random_traffic();
    settle_block();
    if (error_count == 0) begin
      $display("touch_pad_baseline_debounce_test: clean");
    end else begin
      $display("touch_pad_baseline_debounce_test: errors");
    end
    $finish;
  end

endmodule
